>>> rtl/core/lkv_pkg.sv
// shared constants, types and command codes of the lru key/value cache
package lkv_pkg;

	localparam int DEPTH       = 16;
	localparam int KEY_WIDTH   = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int CAP_WIDTH   = 5;
	localparam int OCC_WIDTH   = $clog2(DEPTH + 1);
	localparam int CMP_WIDTH   = (OCC_WIDTH > CAP_WIDTH) ? OCC_WIDTH : CAP_WIDTH;

	localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(16);

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_PUT = 1'b1
	} cmd_t;

	// one entry as held by a cell and handed to its neighbor
	typedef struct packed {
		logic                   valid;
		logic [KEY_WIDTH-1:0]   key;
		logic [VALUE_WIDTH-1:0] value;
	} entry_t;

	// per-beat control broadcast to every cell
	typedef struct packed {
		logic                 move;
		logic                 hit;
		logic                 full;
		logic [KEY_WIDTH-1:0] key;
	} cell_ctl_t;

	// match summary rippling from the least recent cell toward the front
	typedef struct packed {
		logic                   match;
		logic [VALUE_WIDTH-1:0] value;
	} cell_sum_t;

endpackage

>>> rtl/core/lkv_if.sv
// request and response channel interfaces
interface lkv_req_if import lkv_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   command;
	logic [KEY_WIDTH-1:0]   key;
	logic [VALUE_WIDTH-1:0] write_value;

	modport source (output valid, output command, output key, output write_value, input ready);
	modport sink (input valid, input command, input key, input write_value, output ready);
endinterface

interface lkv_rsp_if import lkv_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   hit;
	logic [VALUE_WIDTH-1:0] read_value;

	modport source (output valid, output hit, output read_value, input ready);
	modport sink (input valid, input hit, input read_value, output ready);
endinterface

>>> rtl/core/lkv_cell.sv
// one recency position: holds an entry, matches the key, shifts from its neighbor
module lkv_cell import lkv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    prev,
	input  cell_sum_t sum_in,
	output entry_t    cur,
	output cell_sum_t sum_out
);

	logic   valid_q;
	logic   [KEY_WIDTH-1:0] key_q;
	logic   [VALUE_WIDTH-1:0] value_q;
	logic   match;
	logic   shift;

	assign cur = '{valid: valid_q, key: key_q, value: value_q};

	// associative compare and ripple of the match summary
	assign match         = valid_q && (key_q == ctl.key);
	assign sum_out.match = match | sum_in.match;
	assign sum_out.value = match ? value_q : sum_in.value;

	// shift when this position lies at or above the target position
	always_comb begin
		if (ctl.hit) begin
			shift = ctl.move & (match | sum_in.match);
		end else if (ctl.full) begin
			shift = ctl.move & valid_q;
		end else begin
			shift = ctl.move & (valid_q | prev.valid);
		end
	end

	// valid mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= prev.valid;
		end
	end

	// key and value
	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= prev.key;
			value_q <= prev.value;
		end
	end

endmodule

>>> rtl/core/lru_key_value_cache.sv
// lru key/value cache: one cell per recency position, most recent at the front
// response: registered, its beat follows in the cycle after the request beat
// throughput: one request per cycle; match, move-to-front and insert are done
// by the cell row in the cycle of the beat, a stalled response holds the request
// reset: all entries empty, occupancy zero, capacity 16; usable in the first cycle
module lru_key_value_cache import lkv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	lkv_req_if.sink              req,
	lkv_rsp_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [CAP_WIDTH-1:0] cfg_wdata
);

	logic                   [CAP_WIDTH-1:0] cap_q;
	logic                   [OCC_WIDTH-1:0] occ_q;
	logic                   rsp_valid_q;
	logic                   rsp_hit_q;
	logic                   [VALUE_WIDTH-1:0] rsp_value_q;
	logic                   accept;
	logic                   full;
	logic                   [CMP_WIDTH-1:0] occ_ext;
	logic                   [CMP_WIDTH-1:0] cap_ext;
	cell_ctl_t              ctl;
	entry_t                 front;
	entry_t                 ent [DEPTH+1];
	cell_sum_t              sum [DEPTH+1];

	assign accept    = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// full when occupancy reaches the clamped capacity, a zero capacity acting as one
	assign occ_ext = CMP_WIDTH'(occ_q);
	assign cap_ext = CMP_WIDTH'(cap_q);
	assign full    = (occ_ext >= CMP_WIDTH'(DEPTH)) || ((cap_q != '0) && (occ_ext >= cap_ext))
	                 || ((cap_q == '0) && (occ_q != '0));

	// control broadcast and front entry
	assign ctl.key  = req.key;
	assign ctl.hit  = sum[0].match;
	assign ctl.full = full;
	assign ctl.move = accept && (sum[0].match || (req.command == CMD_PUT));

	assign front.valid = 1'b1;
	assign front.key   = req.key;
	assign front.value = (req.command == CMD_PUT) ? req.write_value : sum[0].value;

	assign ent[0]     = front;
	assign sum[DEPTH] = '{match: 1'b0, value: '0};

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		lkv_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.prev    (ent[i]),
			.sum_in  (sum[i+1]),
			.cur     (ent[i+1]),
			.sum_out (sum[i])
		);
	end

	// occupancy grows on a new key while below capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (accept && (req.command == CMD_PUT) && !sum[0].match && !full) begin
			occ_q <= occ_q + OCC_WIDTH'(1);
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_hit_q   <= (req.command == CMD_PUT) || sum[0].match;
			rsp_value_q <= ((req.command == CMD_GET) && sum[0].match) ? sum[0].value : '0;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.hit        = rsp_hit_q;
	assign rsp.read_value = rsp_value_q;

endmodule

>>> rtl/core/lkv_checker.sv
// port-level checks for the lru key/value cache
module lkv_checker import lkv_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  logic                   req_ready,
	input  logic                   req_command,
	input  logic                   rsp_valid,
	input  logic                   rsp_ready,
	input  logic                   rsp_hit,
	input  logic [VALUE_WIDTH-1:0] rsp_read_value
);

	// a stalled response beat stays
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value))
		else $error("response dropped or changed while stalled");

	// a miss carries a zero value
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_hit |-> rsp_read_value == '0)
		else $error("miss with nonzero value");

	// a put beat answers next cycle with success and zero value
	a_put_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_command == CMD_PUT)
		|=> rsp_valid && rsp_hit && (rsp_read_value == '0))
		else $error("put not answered with success");

	// a request is taken only while the response side can move
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while response stalled");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_command    (req.command),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_hit        (rsp.hit),
	.rsp_read_value (rsp.read_value)
);
